// ===== hdl/c8ie_pkg.sv =====
`timescale 1ns / 1ps
package c8ie_pkg;

  // Fixed geometry
  localparam int MEM_BYTES       = 4096;
  localparam int MEM_AW          = 12;
  localparam int SCREEN_WIDTH    = 64;
  localparam int SCREEN_HEIGHT   = 32;
  localparam int ROW_AW          = 5;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int IN_DATA_W       = 48;
  localparam int OUT_DATA_W      = 96;

  localparam logic [15:0] FONT_BASE = 16'h0050;
  localparam logic [11:0] START_PC  = 12'h200;
  localparam logic [11:0] FETCH_TOP = 12'd4094;

  // Request kinds on in_tuser
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Opcode sub-fields
  localparam logic [7:0] NN_CLS   = 8'hE0;
  localparam logic [7:0] NN_RET   = 8'hEE;
  localparam logic [7:0] NN_SKP   = 8'h9E;
  localparam logic [7:0] NN_SKNP  = 8'hA1;
  localparam logic [7:0] NN_LDDT  = 8'h07;
  localparam logic [7:0] NN_WAITK = 8'h0A;
  localparam logic [7:0] NN_SETDT = 8'h15;
  localparam logic [7:0] NN_SETST = 8'h18;
  localparam logic [7:0] NN_ADDI  = 8'h1E;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_LOAD  = 8'h65;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef enum logic [4:0] {
    K_CLS, K_RET, K_JP, K_CALL, K_SE_I, K_SNE_I, K_SE_R, K_SNE_R,
    K_LD_I, K_ADD_I, K_ALU, K_ALUF, K_LDI, K_JPV0, K_RND, K_DRW,
    K_SKP, K_SKNP, K_LDDT, K_SETDT, K_SETST, K_ADDI, K_WAITK, K_FONT,
    K_BCD, K_STORE, K_LOAD, K_UNK
  } kind_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MEMWR, ST_TICK, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE,
    ST_RD_X, ST_RD_Y, ST_EXEC, ST_FLAG, ST_DRAW_RD, ST_DRAW_WR, ST_DRAW_END,
    ST_BCD, ST_STORE, ST_LD_RD, ST_LD_WR, ST_IDX, ST_DONE
  } ctrl_state_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_CLEAR, DP_LATCH, DP_MEMWR, DP_TICK, DP_FETCH_HI, DP_FETCH_LO,
    DP_DECODE, DP_RD_X, DP_RD_Y, DP_EXEC, DP_FLAG, DP_DRAW_RD, DP_DRAW_WR,
    DP_DRAW_END, DP_BCD, DP_STORE, DP_LD_RD, DP_LD_WR, DP_IDX, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  clr_last;
    logic  draw_stop;
    logic  reg_last;
    logic  bcd_last;
    logic  out_busy;
  } sts_t;

  // Classify one instruction word
  function automatic kind_t decode_kind(input logic [15:0] op);
    kind_t k;
    k = K_UNK;
    unique case (op[15:12])
      4'h0: begin
        if (op[7:0] == NN_CLS) k = K_CLS;
        else if (op[7:0] == NN_RET) k = K_RET;
      end
      4'h1: k = K_JP;
      4'h2: k = K_CALL;
      4'h3: k = K_SE_I;
      4'h4: k = K_SNE_I;
      4'h5: k = K_SE_R;
      4'h6: k = K_LD_I;
      4'h7: k = K_ADD_I;
      4'h8: begin
        if (op[3:0] == ALU_MOV || op[3:0] == ALU_OR || op[3:0] == ALU_AND ||
            op[3:0] == ALU_XOR) k = K_ALU;
        else if (op[3:0] == ALU_ADD || op[3:0] == ALU_SUB || op[3:0] == ALU_SHR ||
                 op[3:0] == ALU_SUBN || op[3:0] == ALU_SHL) k = K_ALUF;
      end
      4'h9: k = K_SNE_R;
      4'hA: k = K_LDI;
      4'hB: k = K_JPV0;
      4'hC: k = K_RND;
      4'hD: k = K_DRW;
      4'hE: begin
        if (op[7:0] == NN_SKP) k = K_SKP;
        else if (op[7:0] == NN_SKNP) k = K_SKNP;
      end
      4'hF: begin
        if (op[7:0] == NN_LDDT) k = K_LDDT;
        else if (op[7:0] == NN_WAITK) k = K_WAITK;
        else if (op[7:0] == NN_SETDT) k = K_SETDT;
        else if (op[7:0] == NN_SETST) k = K_SETST;
        else if (op[7:0] == NN_ADDI) k = K_ADDI;
        else if (op[7:0] == NN_FONT) k = K_FONT;
        else if (op[7:0] == NN_BCD) k = K_BCD;
        else if (op[7:0] == NN_STORE) k = K_STORE;
        else if (op[7:0] == NN_LOAD) k = K_LOAD;
      end
      default: k = K_UNK;
    endcase
    return k;
  endfunction

  // One decimal digit of a byte: sel 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    logic [7:0]  d;
    if (v >= 8'd200) h = 2'd2;
    else if (v >= 8'd100) h = 2'd1;
    else h = 2'd0;
    r = v - ({6'b0, h} * 8'd100);
    // tens by reciprocal multiply, exact for values below 100
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = r - 8'({t, 3'b000} + {t, 1'b0});
    unique case (sel)
      2'd0:    d = {6'b0, h};
      2'd1:    d = {4'b0, t};
      default: d = o;
    endcase
    return d;
  endfunction

  // Index of the highest set key
  function automatic logic [3:0] top_key(input logic [15:0] keys);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (keys[i]) k = 4'(i);
    end
    return k;
  endfunction

endpackage

// ===== hdl/chip8_instruction_executor_core.sv =====
`timescale 1ns / 1ps
// One word at a time: the next word is taken once the result sits in the output
//   register, so the sequencer and its single RAM port set the word rate.
// Reset: synchronous, active low; afterwards a pass over every address zeroes
//   the RAM with in_tready low. Registers, screen and stack clear at once, pc = 0x200.
module chip8_instruction_executor_core #(
  parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // address[11:0], write_data[19:12], keys_pressed[35:20], random_byte[43:36]
  input  logic [c8ie_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // row_bits[63:0], pc_now[75:64], executed_opcode[91:76], sound_on[92],
  // waiting_for_key[93], unknown_opcode[94], stack_fault[95]
  output logic [c8ie_pkg::OUT_DATA_W-1:0] out_tdata
);

  c8ie_pkg::cmd_t cmd;
  c8ie_pkg::sts_t sts;

  c8ie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  c8ie_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // One word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // Key wait only comes from an FX word
  a_wait_is_fx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[93] |-> out_tdata[91:88] == 4'hF)
    else $error("key wait flagged for a non-FX word");

  // Row data and an executed word never share one result
  a_row_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[63:0] != 64'd0) |-> out_tdata[91:76] == 16'h0000)
    else $error("row data on an execute result");

endmodule

// ===== hdl/c8ie_ram.sv =====
`timescale 1ns / 1ps
module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/c8ie_ctrl.sv =====
`timescale 1ns / 1ps
module c8ie_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [1:0]          in_tuser,
  output logic                in_tready,
  input  c8ie_pkg::sts_t      sts,
  output c8ie_pkg::cmd_t      cmd
);

  c8ie_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= c8ie_pkg::ST_CLEAR;
    else state_r <= state_nxt;
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = c8ie_pkg::DP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      c8ie_pkg::ST_CLEAR: begin
        cmd.op = c8ie_pkg::DP_CLEAR;
        if (sts.clr_last) state_nxt = c8ie_pkg::ST_IDLE;
      end
      c8ie_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = c8ie_pkg::DP_LATCH;
          unique case (in_tuser)
            c8ie_pkg::REQ_WRITE: state_nxt = c8ie_pkg::ST_MEMWR;
            c8ie_pkg::REQ_EXEC:  state_nxt = c8ie_pkg::ST_FETCH_HI;
            c8ie_pkg::REQ_TICK:  state_nxt = c8ie_pkg::ST_TICK;
            default:             state_nxt = c8ie_pkg::ST_DONE;
          endcase
        end
      end
      c8ie_pkg::ST_MEMWR: begin
        cmd.op    = c8ie_pkg::DP_MEMWR;
        state_nxt = c8ie_pkg::ST_DONE;
      end
      c8ie_pkg::ST_TICK: begin
        cmd.op    = c8ie_pkg::DP_TICK;
        state_nxt = c8ie_pkg::ST_DONE;
      end
      c8ie_pkg::ST_FETCH_HI: begin
        cmd.op    = c8ie_pkg::DP_FETCH_HI;
        state_nxt = c8ie_pkg::ST_FETCH_LO;
      end
      c8ie_pkg::ST_FETCH_LO: begin
        cmd.op    = c8ie_pkg::DP_FETCH_LO;
        state_nxt = c8ie_pkg::ST_DECODE;
      end
      c8ie_pkg::ST_DECODE: begin
        cmd.op    = c8ie_pkg::DP_DECODE;
        state_nxt = c8ie_pkg::ST_RD_X;
      end
      c8ie_pkg::ST_RD_X: begin
        cmd.op    = c8ie_pkg::DP_RD_X;
        state_nxt = c8ie_pkg::ST_RD_Y;
      end
      c8ie_pkg::ST_RD_Y: begin
        cmd.op    = c8ie_pkg::DP_RD_Y;
        state_nxt = c8ie_pkg::ST_EXEC;
      end
      c8ie_pkg::ST_EXEC: begin
        cmd.op = c8ie_pkg::DP_EXEC;
        priority case (sts.kind)
          c8ie_pkg::K_ALUF, c8ie_pkg::K_ADDI: state_nxt = c8ie_pkg::ST_FLAG;
          c8ie_pkg::K_DRW:   state_nxt = c8ie_pkg::ST_DRAW_RD;
          c8ie_pkg::K_BCD:   state_nxt = c8ie_pkg::ST_BCD;
          c8ie_pkg::K_STORE: state_nxt = c8ie_pkg::ST_STORE;
          c8ie_pkg::K_LOAD:  state_nxt = c8ie_pkg::ST_LD_RD;
          default:           state_nxt = c8ie_pkg::ST_DONE;
        endcase
      end
      c8ie_pkg::ST_FLAG: begin
        cmd.op    = c8ie_pkg::DP_FLAG;
        state_nxt = c8ie_pkg::ST_DONE;
      end
      // sprite rows: read a byte, then merge it into the screen
      c8ie_pkg::ST_DRAW_RD: begin
        cmd.op    = c8ie_pkg::DP_DRAW_RD;
        state_nxt = sts.draw_stop ? c8ie_pkg::ST_DRAW_END : c8ie_pkg::ST_DRAW_WR;
      end
      c8ie_pkg::ST_DRAW_WR: begin
        cmd.op    = c8ie_pkg::DP_DRAW_WR;
        state_nxt = c8ie_pkg::ST_DRAW_RD;
      end
      c8ie_pkg::ST_DRAW_END: begin
        cmd.op    = c8ie_pkg::DP_DRAW_END;
        state_nxt = c8ie_pkg::ST_DONE;
      end
      c8ie_pkg::ST_BCD: begin
        cmd.op = c8ie_pkg::DP_BCD;
        if (sts.bcd_last) state_nxt = c8ie_pkg::ST_DONE;
      end
      c8ie_pkg::ST_STORE: begin
        cmd.op = c8ie_pkg::DP_STORE;
        if (sts.reg_last) state_nxt = c8ie_pkg::ST_IDX;
      end
      c8ie_pkg::ST_LD_RD: begin
        cmd.op    = c8ie_pkg::DP_LD_RD;
        state_nxt = c8ie_pkg::ST_LD_WR;
      end
      c8ie_pkg::ST_LD_WR: begin
        cmd.op    = c8ie_pkg::DP_LD_WR;
        state_nxt = sts.reg_last ? c8ie_pkg::ST_IDX : c8ie_pkg::ST_LD_RD;
      end
      c8ie_pkg::ST_IDX: begin
        cmd.op    = c8ie_pkg::DP_IDX;
        state_nxt = c8ie_pkg::ST_DONE;
      end
      // hand the word to the output register once it is free
      c8ie_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = c8ie_pkg::DP_OUT;
          state_nxt = c8ie_pkg::ST_IDLE;
        end
      end
      default: state_nxt = c8ie_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/c8ie_datapath.sv =====
`timescale 1ns / 1ps
module c8ie_datapath #(
  parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  c8ie_pkg::cmd_t                  cmd,
  output c8ie_pkg::sts_t                  sts,
  input  logic [c8ie_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [c8ie_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SI_W = $clog2(STACK_DEPTH);
  localparam int MAW  = c8ie_pkg::MEM_AW;

  // Latched request
  logic [1:0]  req_r, req_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [7:0]  rnd_r, rnd_nxt;

  // Instruction and operands
  logic [7:0]      hi_r, hi_nxt;
  logic [15:0]     op_r, op_nxt;
  c8ie_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]      vx_r, vx_nxt;
  logic [7:0]      vy_r, vy_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            hit_r, hit_nxt;
  logic [7:0]      flag_r, flag_nxt;
  logic            wait_r, wait_nxt;
  logic            unk_r, unk_nxt;
  logic            sf_r, sf_nxt;

  // Machine state
  logic [11:0]     pc_r, pc_nxt;
  logic [15:0]     idx_r, idx_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [7:0]      dt_r, dt_nxt;
  logic [7:0]      st_r, st_nxt;
  logic [MAW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [7:0]      v_r [16];
  logic [7:0]      v_nxt [16];
  logic [11:0]     stack_r [STACK_DEPTH];
  logic [11:0]     stack_nxt [STACK_DEPTH];
  logic [c8ie_pkg::SCREEN_WIDTH-1:0] screen_r [c8ie_pkg::SCREEN_HEIGHT];
  logic [c8ie_pkg::SCREEN_WIDTH-1:0] screen_nxt [c8ie_pkg::SCREEN_HEIGHT];
  logic                              out_valid_r, out_valid_nxt;
  logic [c8ie_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  // RAM port
  logic           mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;

  // Decoded fields and helpers
  logic [3:0]  op_x, op_y, op_n;
  logic [7:0]  op_nn;
  logic [11:0] op_nnn;
  logic [3:0]  v_ra;
  logic [7:0]  v_rd;
  logic [5:0]  draw_row;
  logic [11:0] idx_cnt;
  logic [15:0] fetch_word;
  logic [c8ie_pkg::SCREEN_WIDTH-1:0] spr_mask;
  logic [SP_W-1:0] sp_e;
  logic [8:0]  alu_sum;
  logic [15:0] idx_sum;

  assign op_x     = op_r[11:8];
  assign op_y     = op_r[7:4];
  assign op_n     = op_r[3:0];
  assign op_nn    = op_r[7:0];
  assign op_nnn   = op_r[11:0];
  assign draw_row = {1'b0, vy_r[4:0]} + {2'b0, cnt_r};
  assign idx_cnt  = idx_r[11:0] + {8'b0, cnt_r};
  assign spr_mask = {mem_rdata, 56'b0} >> vx_r[5:0];
  assign fetch_word = {hi_r, (pc_r < c8ie_pkg::FETCH_TOP) ? mem_rdata : 8'h00};

  // Read port of the V file for X, Y and the store loop; V0 is also read directly
  always_comb begin
    priority if (cmd.op == c8ie_pkg::DP_RD_X) v_ra = op_x;
    else if (cmd.op == c8ie_pkg::DP_RD_Y) v_ra = op_y;
    else v_ra = cnt_r;
  end
  assign v_rd = v_r[v_ra];

  // Status to the controller
  assign sts.kind      = kind_r;
  assign sts.clr_last  = &clr_addr_r;
  assign sts.draw_stop = (cnt_r == op_n) || draw_row[5];
  assign sts.reg_last  = (cnt_r == op_x);
  assign sts.bcd_last  = (cnt_r == 4'd2);
  assign sts.out_busy  = out_valid_r & ~out_tready;

  c8ie_ram #(
    .WIDTH (8),
    .DEPTH (c8ie_pkg::MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Datapath operations
  always_comb begin
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    keys_nxt      = keys_r;
    rnd_nxt       = rnd_r;
    hi_nxt        = hi_r;
    op_nxt        = op_r;
    kind_nxt      = kind_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    flag_nxt      = flag_r;
    wait_nxt      = wait_r;
    unk_nxt       = unk_r;
    sf_nxt        = sf_r;
    pc_nxt        = pc_r;
    idx_nxt       = idx_r;
    sp_nxt        = sp_r;
    dt_nxt        = dt_r;
    st_nxt        = st_r;
    clr_addr_nxt  = clr_addr_r;
    v_nxt         = v_r;
    stack_nxt     = stack_r;
    screen_nxt    = screen_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_cnt;
    mem_wdata     = 8'h00;
    mem_raddr     = pc_r;
    sp_e          = sp_r;
    alu_sum       = 9'd0;
    idx_sum       = 16'd0;
    unique case (cmd.op)
      c8ie_pkg::DP_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      c8ie_pkg::DP_LATCH: begin
        // tdata: address, write_data, keys_pressed, random_byte
        req_nxt   = in_tuser;
        addr_nxt  = in_tdata[11:0];
        wdata_nxt = in_tdata[19:12];
        keys_nxt  = in_tdata[35:20];
        rnd_nxt   = in_tdata[43:36];
        op_nxt    = 16'h0000;
        wait_nxt  = 1'b0;
        unk_nxt   = 1'b0;
        sf_nxt    = 1'b0;
      end
      c8ie_pkg::DP_MEMWR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = wdata_r;
      end
      c8ie_pkg::DP_TICK: begin
        if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
        if (st_r != 8'd0) st_nxt = st_r - 8'd1;
      end
      c8ie_pkg::DP_FETCH_HI: mem_raddr = pc_r;
      c8ie_pkg::DP_FETCH_LO: begin
        mem_raddr = pc_r + 12'd1;
        hi_nxt    = mem_rdata;
      end
      c8ie_pkg::DP_DECODE: begin
        op_nxt   = fetch_word;
        kind_nxt = c8ie_pkg::decode_kind(fetch_word);
        pc_nxt   = pc_r + 12'd2;
      end
      c8ie_pkg::DP_RD_X: vx_nxt = v_rd;
      c8ie_pkg::DP_RD_Y: vy_nxt = v_rd;
      c8ie_pkg::DP_EXEC: begin
        cnt_nxt = 4'd0;
        hit_nxt = 1'b0;
        unique case (kind_r)
          c8ie_pkg::K_CLS: begin
            for (int r = 0; r < c8ie_pkg::SCREEN_HEIGHT; r++) screen_nxt[r] = '0;
          end
          c8ie_pkg::K_RET: begin
            if (sp_r == '0 || sp_r > SP_W'(STACK_DEPTH)) begin
              sf_nxt = 1'b1;
              sp_e   = SP_W'(STACK_DEPTH);
            end
            sp_nxt = sp_e - 1'b1;
            pc_nxt = stack_r[sp_nxt[SI_W-1:0]];
          end
          c8ie_pkg::K_CALL: begin
            if (sp_r >= SP_W'(STACK_DEPTH)) begin
              sf_nxt = 1'b1;
              sp_e   = '0;
            end
            stack_nxt[sp_e[SI_W-1:0]] = pc_r;
            sp_nxt = sp_e + 1'b1;
            pc_nxt = op_nnn;
          end
          c8ie_pkg::K_JP:    pc_nxt = op_nnn;
          c8ie_pkg::K_SE_I:  if (vx_r == op_nn) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::K_SNE_I: if (vx_r != op_nn) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::K_SE_R:  if (vx_r == vy_r) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::K_SNE_R: if (vx_r != vy_r) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::K_LD_I:  v_nxt[op_x] = op_nn;
          c8ie_pkg::K_ADD_I: v_nxt[op_x] = vx_r + op_nn;
          c8ie_pkg::K_ALU: begin
            unique case (op_n[1:0])
              2'd0:    v_nxt[op_x] = vy_r;
              2'd1:    v_nxt[op_x] = vx_r | vy_r;
              2'd2:    v_nxt[op_x] = vx_r & vy_r;
              default: v_nxt[op_x] = vx_r ^ vy_r;
            endcase
          end
          // result now, flag to VF in the next cycle
          c8ie_pkg::K_ALUF: begin
            priority case (op_n)
              c8ie_pkg::ALU_ADD: begin
                alu_sum     = {1'b0, vx_r} + {1'b0, vy_r};
                v_nxt[op_x] = alu_sum[7:0];
                flag_nxt    = {7'b0, alu_sum[8]};
              end
              c8ie_pkg::ALU_SUB: begin
                v_nxt[op_x] = vx_r - vy_r;
                flag_nxt    = {7'b0, vx_r >= vy_r};
              end
              c8ie_pkg::ALU_SUBN: begin
                v_nxt[op_x] = vy_r - vx_r;
                flag_nxt    = {7'b0, vy_r >= vx_r};
              end
              c8ie_pkg::ALU_SHR: begin
                v_nxt[op_x] = {1'b0, vy_r[7:1]};
                flag_nxt    = {7'b0, vy_r[0]};
              end
              default: begin
                v_nxt[op_x] = {vy_r[6:0], 1'b0};
                flag_nxt    = {7'b0, vy_r[7]};
              end
            endcase
          end
          c8ie_pkg::K_LDI:  idx_nxt = {4'b0, op_nnn};
          c8ie_pkg::K_JPV0: pc_nxt = op_nnn + {4'b0, v_r[0]};
          c8ie_pkg::K_RND:  v_nxt[op_x] = rnd_r & op_nn;
          c8ie_pkg::K_SKP:  if (keys_r[vx_r[3:0]]) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::K_SKNP: if (!keys_r[vx_r[3:0]]) pc_nxt = pc_r + 12'd2;
          c8ie_pkg::K_LDDT:  v_nxt[op_x] = dt_r;
          c8ie_pkg::K_SETDT: dt_nxt = vx_r;
          c8ie_pkg::K_SETST: st_nxt = vx_r;
          c8ie_pkg::K_ADDI: begin
            idx_sum  = idx_r + {8'b0, vx_r};
            idx_nxt  = idx_sum;
            flag_nxt = {7'b0, |idx_sum[15:12]};
          end
          c8ie_pkg::K_WAITK: begin
            if (keys_r == 16'h0000) begin
              pc_nxt   = pc_r - 12'd2;
              wait_nxt = 1'b1;
            end else begin
              v_nxt[op_x] = {4'b0, c8ie_pkg::top_key(keys_r)};
            end
          end
          c8ie_pkg::K_FONT:
            idx_nxt = c8ie_pkg::FONT_BASE + {6'b0, vx_r, 2'b00} + {8'b0, vx_r};
          c8ie_pkg::K_UNK: unk_nxt = 1'b1;
          default: ;
        endcase
      end
      c8ie_pkg::DP_FLAG: v_nxt[15] = flag_r;
      c8ie_pkg::DP_DRAW_RD: mem_raddr = idx_cnt;
      // XOR one sprite row, note any pixel turned off
      c8ie_pkg::DP_DRAW_WR: begin
        if (|(screen_r[draw_row[4:0]] & spr_mask)) hit_nxt = 1'b1;
        screen_nxt[draw_row[4:0]] = screen_r[draw_row[4:0]] ^ spr_mask;
        cnt_nxt = cnt_r + 4'd1;
      end
      c8ie_pkg::DP_DRAW_END: v_nxt[15] = {7'b0, hit_r};
      c8ie_pkg::DP_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = c8ie_pkg::bcd_digit(vx_r, cnt_r[1:0]);
        cnt_nxt   = cnt_r + 4'd1;
      end
      c8ie_pkg::DP_STORE: begin
        mem_we    = 1'b1;
        mem_wdata = v_rd;
        cnt_nxt   = cnt_r + 4'd1;
      end
      c8ie_pkg::DP_LD_RD: mem_raddr = idx_cnt;
      c8ie_pkg::DP_LD_WR: begin
        v_nxt[cnt_r] = mem_rdata;
        cnt_nxt      = cnt_r + 4'd1;
      end
      c8ie_pkg::DP_IDX: idx_nxt = idx_r + {12'b0, op_x} + 16'd1;
      c8ie_pkg::DP_OUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {sf_r, unk_r, wait_r, (st_r != 8'd0), op_r, pc_r,
                         (req_r == c8ie_pkg::REQ_READ) ? screen_r[addr_r[4:0]]
                                                       : 64'd0};
      end
      default: ;
    endcase
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= c8ie_pkg::START_PC;
      idx_r       <= '0;
      sp_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stack_r[i] <= '0;
      for (int i = 0; i < c8ie_pkg::SCREEN_HEIGHT; i++) screen_r[i] <= '0;
    end else begin
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      sp_r        <= sp_nxt;
      dt_r        <= dt_nxt;
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      v_r         <= v_nxt;
      stack_r     <= stack_nxt;
      screen_r    <= screen_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    wdata_r    <= wdata_nxt;
    keys_r     <= keys_nxt;
    rnd_r      <= rnd_nxt;
    hi_r       <= hi_nxt;
    op_r       <= op_nxt;
    kind_r     <= kind_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    cnt_r      <= cnt_nxt;
    hit_r      <= hit_nxt;
    flag_r     <= flag_nxt;
    wait_r     <= wait_nxt;
    unk_r      <= unk_nxt;
    sf_r       <= sf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
